### sv/art_pkg.sv
// ----------------------------------------------------------------------------
// art_pkg
// Shared types and constants of the address region table.
// ----------------------------------------------------------------------------
`default_nettype none

package art_pkg;

  localparam int REGION_SLOTS = 16;
  localparam int ADDR_BITS    = 48;
  localparam int SLOT_W       = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;

  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_FIND   = 2'd2;

  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [SLOT_W-1:0]    slot_idx_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [47:0] base_addr;
    logic [47:0] limit_addr;
    logic [47:0] length;
    logic [31:0] attr_flags;
  } in_t;

  typedef struct packed {
    logic        status;
    logic        hit;
    logic [3:0]  slot;
    logic [47:0] found_start;
    logic [47:0] found_end;
    logic [31:0] found_flags;
  } out_t;

  typedef struct packed {
    addr_t       start_a;
    addr_t       end_a;
    logic [31:0] flags;
  } entry_t;

  typedef struct packed {
    logic        en;
    logic        clr;
    slot_idx_t   idx;
    entry_t      ent;
  } wr_t;

endpackage

`default_nettype wire

### sv/art_store.sv
// ----------------------------------------------------------------------------
// art_store
// Region table storage: one read port at the scan index, one write port.
// ----------------------------------------------------------------------------
`default_nettype none

module art_store
  import art_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire slot_idx_t rd_idx,
  output entry_t         rd_ent,
  input  wire wr_t       wr
);

  addr_t       start_q [REGION_SLOTS];
  addr_t       end_q   [REGION_SLOTS];
  logic [31:0] flags_q [REGION_SLOTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REGION_SLOTS; i++) begin
        start_q[i] <= '0;
        end_q[i]   <= '0;
        flags_q[i] <= '0;
      end
    end else if (wr.en) begin
      if (wr.clr) begin
        start_q[wr.idx] <= '0;
        end_q[wr.idx]   <= '0;
      end else begin
        start_q[wr.idx] <= wr.ent.start_a;
        end_q[wr.idx]   <= wr.ent.end_a;
        flags_q[wr.idx] <= wr.ent.flags;
      end
    end
  end

  assign rd_ent.start_a = start_q[rd_idx];
  assign rd_ent.end_a   = end_q[rd_idx];
  assign rd_ent.flags   = flags_q[rd_idx];

endmodule

`default_nettype wire

### sv/art_cmp.sv
// ----------------------------------------------------------------------------
// art_cmp
// Shared slot compare unit: tests one slot against the current operation.
// ----------------------------------------------------------------------------
`default_nettype none

module art_cmp
  import art_pkg::*;
(
  input  wire logic [1:0]           kind,
  input  wire entry_t               ent,
  input  wire addr_t                base,
  input  wire logic [ADDR_BITS:0]   rend,
  output logic                      match
);

  logic empty;
  logic valid;
  logic overlap;
  logic contain;

  assign empty   = ent.start_a == ent.end_a;
  assign valid   = ent.start_a < ent.end_a;
  assign overlap = valid && (ent.end_a > base) && ({1'b0, ent.start_a} < rend);
  assign contain = valid && (base >= ent.start_a) && (base < ent.end_a);

  always_comb begin
    case (kind)
      KIND_ADD:    match = empty;
      KIND_REMOVE: match = overlap;
      KIND_FIND:   match = contain;
      default:     match = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

### sv/address_region_table_core.sv
// ----------------------------------------------------------------------------
// address_region_table_core
// An item scans one slot per cycle, up to all REGION_SLOTS (16) slots;
//   add and find stop at the first matching slot, remove and misses scan all.
// The result strobe comes the cycle after the last scan cycle; busy is high
//   during the scan, and a new start is taken in the strobe cycle.
// Only one item is in flight; the single shared compare unit tests one slot at a time.
// Reset clears the table at once; the receiver cannot stall results.
// ----------------------------------------------------------------------------
`default_nettype none

module address_region_table_core
  import art_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire in_t  item,
  output logic      busy,
  output logic      done,
  output out_t      result
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic               state;
  slot_idx_t          idx;
  logic [1:0]         kind;
  addr_t              base;
  addr_t              limit;
  logic [31:0]        flags;
  logic [ADDR_BITS:0] rend;

  entry_t ent;
  wr_t    wr;
  logic   match;
  logic   last;
  logic   finish;
  out_t   result_next;

  art_store u_store (
    .clk    (clk),
    .rst    (rst),
    .rd_idx (idx),
    .rd_ent (ent),
    .wr     (wr)
  );

  art_cmp u_cmp (
    .kind  (kind),
    .ent   (ent),
    .base  (base),
    .rend  (rend),
    .match (match)
  );

  assign busy = state == ST_SCAN;
  assign last = idx == SLOT_W'(REGION_SLOTS - 1);

  always_comb begin
    finish      = 1'b0;
    result_next = '0;
    wr          = '0;
    wr.idx      = idx;
    wr.ent      = '{start_a: base, end_a: limit, flags: flags};
    if (state == ST_SCAN) begin
      case (kind)
        KIND_ADD: begin
          if (match) begin
            finish           = 1'b1;
            wr.en            = 1'b1;
            result_next.slot = 4'(idx);
          end else if (last) begin
            finish             = 1'b1;
            result_next.status = 1'b1;
          end
        end
        KIND_REMOVE: begin
          wr.en  = match;
          wr.clr = 1'b1;
          finish = last;
        end
        KIND_FIND: begin
          if (match) begin
            finish                  = 1'b1;
            result_next.hit         = 1'b1;
            result_next.slot        = 4'(idx);
            result_next.found_start = 48'(ent.start_a);
            result_next.found_end   = 48'(ent.end_a);
            result_next.found_flags = ent.flags;
          end else begin
            finish = last;
          end
        end
        default: finish = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
      idx   <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_SCAN;
            idx   <= '0;
          end
        end
        ST_SCAN: begin
          if (finish) begin
            state <= ST_IDLE;
            done  <= 1'b1;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      kind  <= item.kind;
      base  <= ADDR_BITS'(item.base_addr);
      limit <= ADDR_BITS'(item.limit_addr);
      flags <= item.attr_flags;
      rend  <= {1'b0, ADDR_BITS'(item.base_addr)} + {1'b0, ADDR_BITS'(item.length)};
    end
    if (state == ST_SCAN && finish) begin
      result <= result_next;
    end
  end

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for more than one cycle");

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while still scanning");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
      (start && !busy) |=> busy)
    else $error("accepted item did not start a scan");

  a_full_no_hit: assert property (@(posedge clk) disable iff (rst)
      (done && result.status) |-> (!result.hit && result.slot == 4'd0))
    else $error("table full result carries hit data");

  a_add_empty: assert property (@(posedge clk) disable iff (rst)
      (wr.en && !wr.clr) |-> (ent.start_a == ent.end_a))
    else $error("add overwrote a non-empty slot");

endmodule

`default_nettype wire
